// ===== rtl/bde_pkg.sv =====
// ============================================================================
// bde_pkg
// Shared types, sizes and register codes of the 4-neighbour binary
// dilate/erode block.
// ============================================================================
package bde_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int DIM_W = 11;
    localparam int PIX_W = 8;

    localparam logic [PIX_W-1:0] PIX_MAX  = 8'd255;
    localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    typedef struct packed {
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
    } line_word_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } result_t;

    typedef struct packed {
        logic [PIX_W-1:0] center;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] below;
        logic             up_en;
        logic             left_en;
        logic             right_en;
        logic             below_en;
        logic             last;
    } job_t;

    function automatic logic [COL_W-1:0] col_last(input logic [DIM_W-1:0] v);
        logic [COL_W-1:0] r;
        if (v == '0)
            r = '0;
        else if (v > DIM_W'(MAX_WIDTH))
            r = COL_W'(MAX_WIDTH - 1);
        else
            r = COL_W'(v - DIM_W'(1));
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] row_last(input logic [DIM_W-1:0] v);
        logic [ROW_W-1:0] r;
        if (v == '0)
            r = '0;
        else if (v > DIM_W'(MAX_HEIGHT))
            r = ROW_W'(MAX_HEIGHT - 1);
        else
            r = ROW_W'(v - DIM_W'(1));
        return r;
    endfunction

endpackage

// ===== rtl/binary_dilate_erode_4n.sv =====
// ============================================================================
// binary_dilate_erode_4n
// One pass of 4-neighbour binary dilation or erosion on a raster pixel
// stream, using a two-row line store and a one-pixel holding register.
// ============================================================================
// Throughput is one word per cycle while the output keeps up; the input stalls
// only when the four-word result queue and job stage together hold four results.
// A result is registered in the job stage and then queued for the output;
// pixel results trail the pixel stream by one row plus one pixel.
// Reset clears all control state and sets 1024 x 1024 dilate; the line store
// is not cleared, since no word read from it before it is written in a frame is used.
module binary_dilate_erode_4n
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] pixel_in
    input  logic                           s_axis_tuser,  // [0] flush

    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,  // [7:0] pixel_out
    output logic                           m_axis_tlast,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bde_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [bde_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [bde_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic [bde_pkg::DIM_W-1:0] width_reg;
    logic [bde_pkg::DIM_W-1:0] height_reg;
    logic                      erode_reg;
    logic [bde_pkg::COL_W-1:0] wm1_reg;
    logic [bde_pkg::ROW_W-1:0] hm1_reg;

    logic [bde_pkg::COL_W-1:0] in_col_reg,  in_col_next;
    logic [bde_pkg::ROW_W-1:0] in_row_reg,  in_row_next;
    logic [bde_pkg::COL_W-1:0] out_col_reg, out_col_next;
    logic [bde_pkg::ROW_W-1:0] out_row_reg, out_row_next;
    logic                      all_in_reg,  all_in_next;
    logic                      hold_valid_reg, hold_valid_next;
    logic [bde_pkg::PIX_W-1:0] hold_pix_reg, hold_pix_next;
    logic [bde_pkg::COL_W-1:0] hold_col_reg, hold_col_next;
    logic [bde_pkg::ROW_W-1:0] hold_row_reg, hold_row_next;
    logic [bde_pkg::PIX_W-1:0] left_reg, left_next;
    logic                      job_valid_reg;
    bde_pkg::job_t             job_reg, job_next;

    logic                      cfg_wr;
    logic                      accept;
    logic                      pix_acc;
    logic                      fl_acc;
    logic                      below_prod;
    logic                      first_row_flush;
    logic                      empty_flush;
    logic                      produce;
    logic                      last_pix;
    logic [bde_pkg::PIX_W-1:0] center;
    logic                      mem_wr_en;
    logic                      mem_rd_en;
    logic [bde_pkg::COL_W-1:0] mem_rd_addr;
    bde_pkg::line_word_t       mem_wr_data;
    bde_pkg::line_word_t       mem_rd_data;

    logic                           any_zero;
    logic                           any_set;
    bde_pkg::result_t               result;
    logic [bde_pkg::OUT_CNT_W-1:0]  fifo_count;
    bde_pkg::result_t               out_word;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bde_pkg::DIM_W'(bde_pkg::MAX_WIDTH);
            height_reg <= bde_pkg::DIM_W'(bde_pkg::MAX_HEIGHT);
            erode_reg  <= 1'b0;
            wm1_reg    <= bde_pkg::COL_W'(bde_pkg::MAX_WIDTH - 1);
            hm1_reg    <= bde_pkg::ROW_W'(bde_pkg::MAX_HEIGHT - 1);
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                bde_pkg::REG_WIDTH:
                begin
                    width_reg <= pwdata[bde_pkg::DIM_W-1:0];
                    wm1_reg   <= bde_pkg::col_last(pwdata[bde_pkg::DIM_W-1:0]);
                end
                bde_pkg::REG_HEIGHT:
                begin
                    height_reg <= pwdata[bde_pkg::DIM_W-1:0];
                    hm1_reg    <= bde_pkg::row_last(pwdata[bde_pkg::DIM_W-1:0]);
                end
                bde_pkg::REG_MODE:
                begin
                    erode_reg <= pwdata[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            bde_pkg::REG_WIDTH:  prdata = bde_pkg::CFG_DATA_W'(width_reg);
            bde_pkg::REG_HEIGHT: prdata = bde_pkg::CFG_DATA_W'(height_reg);
            bde_pkg::REG_MODE:   prdata = bde_pkg::CFG_DATA_W'(erode_reg);
            default:             prdata = '0;
        endcase
    end

    assign s_axis_tready = ({1'b0, fifo_count} + (bde_pkg::OUT_CNT_W + 1)'(job_valid_reg))
                           < (bde_pkg::OUT_CNT_W + 1)'(bde_pkg::OUT_DEPTH);
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign pix_acc = accept && !s_axis_tuser && !all_in_reg;
    assign fl_acc  = accept && s_axis_tuser && all_in_reg;

    assign below_prod      = (pix_acc || fl_acc) && hold_valid_reg && (hold_row_reg != '0);
    assign first_row_flush = fl_acc && hold_valid_reg && (hold_row_reg == '0);
    assign empty_flush     = fl_acc && !hold_valid_reg;
    assign produce         = below_prod || first_row_flush || empty_flush;
    assign last_pix        = (in_col_reg == wm1_reg) && (in_row_reg == hm1_reg);

    // With a single-row frame the newest pixel is the only copy of column 0
    // when the row is one pixel wide.
    assign center = (first_row_flush && (wm1_reg == '0)) ? hold_pix_reg : mem_rd_data.mid;

    assign mem_wr_en       = (pix_acc || fl_acc) && hold_valid_reg;
    assign mem_wr_data.up  = mem_rd_data.mid;
    assign mem_wr_data.mid = hold_pix_reg;
    assign mem_rd_en       = pix_acc || fl_acc;

    always_comb
    begin
        if (fl_acc)
        begin
            if (below_prod)
                mem_rd_addr = '0;
            else if (first_row_flush)
                mem_rd_addr = bde_pkg::COL_W'(1);
            else
                mem_rd_addr = out_col_reg + bde_pkg::COL_W'(1);
        end
        else if (last_pix && (hm1_reg == '0))
        begin
            mem_rd_addr = '0;
        end
        else
        begin
            mem_rd_addr = in_col_reg;
        end
    end

    bde_line_mem u_line_mem
    (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (hold_col_reg),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_comb
    begin
        job_next.center   = center;
        job_next.up       = mem_rd_data.up;
        job_next.left     = left_reg;
        job_next.below    = hold_pix_reg;
        job_next.up_en    = (out_row_reg != '0);
        job_next.left_en  = (out_col_reg != '0);
        job_next.right_en = (out_col_reg != wm1_reg);
        job_next.below_en = below_prod;
        job_next.last     = (out_row_reg == hm1_reg) && (out_col_reg == wm1_reg);
    end

    always_comb
    begin
        in_col_next     = in_col_reg;
        in_row_next     = in_row_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        all_in_next     = all_in_reg;
        hold_valid_next = hold_valid_reg;
        hold_pix_next   = hold_pix_reg;
        hold_col_next   = hold_col_reg;
        hold_row_next   = hold_row_reg;
        left_next       = left_reg;

        if (pix_acc)
        begin
            hold_valid_next = 1'b1;
            hold_pix_next   = s_axis_tdata;
            hold_col_next   = in_col_reg;
            hold_row_next   = in_row_reg;
            if (in_col_reg == wm1_reg)
            begin
                in_col_next = '0;
                if (in_row_reg == hm1_reg)
                begin
                    in_row_next = '0;
                    all_in_next = 1'b1;
                end
                else
                begin
                    in_row_next = in_row_reg + bde_pkg::ROW_W'(1);
                end
            end
            else
            begin
                in_col_next = in_col_reg + bde_pkg::COL_W'(1);
            end
        end

        if (fl_acc)
        begin
            hold_valid_next = 1'b0;
        end

        if (produce)
        begin
            left_next = center;
            if (job_next.last)
            begin
                out_col_next    = '0;
                out_row_next    = '0;
                in_col_next     = '0;
                in_row_next     = '0;
                all_in_next     = 1'b0;
                hold_valid_next = 1'b0;
            end
            else if (out_col_reg == wm1_reg)
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + bde_pkg::ROW_W'(1);
            end
            else
            begin
                out_col_next = out_col_reg + bde_pkg::COL_W'(1);
            end
        end

        if (cfg_wr && (paddr[3:2] <= bde_pkg::REG_MODE))
        begin
            in_col_next     = '0;
            in_row_next     = '0;
            out_col_next    = '0;
            out_row_next    = '0;
            all_in_next     = 1'b0;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            all_in_reg     <= 1'b0;
            hold_valid_reg <= 1'b0;
            job_valid_reg  <= 1'b0;
        end
        else
        begin
            in_col_reg     <= in_col_next;
            in_row_reg     <= in_row_next;
            out_col_reg    <= out_col_next;
            out_row_reg    <= out_row_next;
            all_in_reg     <= all_in_next;
            hold_valid_reg <= hold_valid_next;
            job_valid_reg  <= produce;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_pix_reg <= hold_pix_next;
        hold_col_reg <= hold_col_next;
        hold_row_reg <= hold_row_next;
        left_reg     <= left_next;
        if (produce)
        begin
            job_reg <= job_next;
        end
    end

    // The right neighbor is the line store word fetched with the job.
    always_comb
    begin
        any_zero = (job_reg.up_en    && (job_reg.up    == bde_pkg::PIX_ZERO)) ||
                   (job_reg.left_en  && (job_reg.left  == bde_pkg::PIX_ZERO)) ||
                   (job_reg.right_en && (mem_rd_data.mid == bde_pkg::PIX_ZERO)) ||
                   (job_reg.below_en && (job_reg.below == bde_pkg::PIX_ZERO));
        any_set  = (job_reg.up_en    && (job_reg.up    != bde_pkg::PIX_ZERO)) ||
                   (job_reg.left_en  && (job_reg.left  != bde_pkg::PIX_ZERO)) ||
                   (job_reg.right_en && (mem_rd_data.mid != bde_pkg::PIX_ZERO)) ||
                   (job_reg.below_en && (job_reg.below != bde_pkg::PIX_ZERO));
        result.last  = job_reg.last;
        result.pixel = job_reg.center;
        if (erode_reg)
        begin
            if ((job_reg.center != bde_pkg::PIX_ZERO) && any_zero)
                result.pixel = bde_pkg::PIX_ZERO;
        end
        else
        begin
            if ((job_reg.center == bde_pkg::PIX_ZERO) && any_set)
                result.pixel = bde_pkg::PIX_MAX;
        end
    end

    bde_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_valid_reg),
        .push_data (result),
        .count     (fifo_count),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word)
    );

    assign m_axis_tdata = out_word.pixel;
    assign m_axis_tlast = out_word.last;

endmodule

// ===== rtl/bde_line_mem.sv =====
// ============================================================================
// bde_line_mem
// Line store holding the two previous rows, one word per column, with one
// write port and one registered read port that sees a same-cycle write.
// ============================================================================
module bde_line_mem
(
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [bde_pkg::COL_W-1:0] wr_addr,
    input  bde_pkg::line_word_t       wr_data,
    input  logic                      rd_en,
    input  logic [bde_pkg::COL_W-1:0] rd_addr,
    output bde_pkg::line_word_t       rd_data
);

    bde_pkg::line_word_t mem [bde_pkg::MAX_WIDTH];
    bde_pkg::line_word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
                rd_data_reg <= wr_data;
            else
                rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/bde_out_fifo.sv =====
// ============================================================================
// bde_out_fifo
// Small result queue that decouples the output stream from the input side.
// ============================================================================
module bde_out_fifo
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  bde_pkg::result_t              push_data,
    output logic [bde_pkg::OUT_CNT_W-1:0] count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bde_pkg::result_t              out_word
);

    bde_pkg::result_t               entry_reg [bde_pkg::OUT_DEPTH];
    logic [bde_pkg::OUT_PTR_W-1:0]  wr_ptr_reg;
    logic [bde_pkg::OUT_PTR_W-1:0]  wr_ptr_next;
    logic [bde_pkg::OUT_PTR_W-1:0]  rd_ptr_reg;
    logic [bde_pkg::OUT_PTR_W-1:0]  rd_ptr_next;
    logic [bde_pkg::OUT_CNT_W-1:0]  count_reg;
    logic [bde_pkg::OUT_CNT_W-1:0]  count_next;
    logic                           pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_word  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + bde_pkg::OUT_PTR_W'(1);
        if (pop)
            rd_ptr_next = rd_ptr_reg + bde_pkg::OUT_PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + bde_pkg::OUT_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - bde_pkg::OUT_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
